FILE: sv/wiener_restoration_filter_core_defines.svh
// Assertion macros shared by the Wiener restoration filter RTL.
`ifndef WIENER_RESTORATION_FILTER_CORE_DEFINES_SVH
`define WIENER_RESTORATION_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define WRF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define WRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/wrf_pkg.sv
// Shared types, constants and coefficient helper for the Wiener restoration filter.
`timescale 1ns / 1ps
package wrf_pkg;

  localparam int N_TAPS    = 7;
  localparam int N_ROWS    = 6;
  localparam int SAMP_W    = 12;
  localparam int PIX_W     = 12;
  localparam int TAP_W     = 8;
  localparam int COEF_W    = 11;
  localparam int OPND_W    = 17;
  localparam int PROD_W    = 28;
  localparam int ACC_W     = 32;
  localparam int HV_W      = 16;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CMP_W     = 13;

  localparam logic [1:0] DEPTH_8  = 2'd0;
  localparam logic [1:0] DEPTH_10 = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_H_TAP0,
    REG_H_TAP1,
    REG_H_TAP2,
    REG_V_TAP0,
    REG_V_TAP1,
    REG_V_TAP2,
    REG_DEPTH_MODE,
    REG_LINE_WIDTH
  } reg_idx_t;

  typedef logic [2:0][TAP_W-1:0] tap_set_t;

  typedef struct packed {
    logic       load;
    logic       h_acc;
    logic       h_fin;
    logic       rd_en;
    logic       v_acc;
    logic       v_fin;
    logic       wr_en;
    logic       shift;
    logic       out_load;
    logic       row_end;
    logic [2:0] tap;
    logic [2:0] rd_slot;
    logic [2:0] wr_slot;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

  // Coefficient k of the mirrored 7-tap kernel; the center makes the taps sum to 128.
  function automatic logic signed [COEF_W-1:0] tap_coef(tap_set_t t, logic [2:0] k);
    logic signed [COEF_W-1:0] s;
    logic [2:0]               m;
    s = COEF_W'($signed(t[0])) + COEF_W'($signed(t[1])) + COEF_W'($signed(t[2]));
    m = 3'd6 - k;
    if (k < 3'd3) begin
      tap_coef = COEF_W'($signed(t[k[1:0]]));
    end else if (k == 3'd3) begin
      tap_coef = 11'sd128 - (s <<< 1);
    end else begin
      tap_coef = COEF_W'($signed(t[m[1:0]]));
    end
  endfunction

endpackage

FILE: sv/wrf_dp.sv
// Datapath: sample window, shared multiply-accumulate, rounding, line store and output register.
`timescale 1ns / 1ps
module wrf_dp #(
  parameter int MAX_LINE = 256,
  parameter int AW       = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wrf_pkg::cmd_t                 cmd,
  input  logic [AW-1:0]                 x,
  input  logic [wrf_pkg::SAMP_W-1:0]    sample_in,
  input  wrf_pkg::tap_set_t             h_taps,
  input  wrf_pkg::tap_set_t             v_taps,
  input  logic [1:0]                    depth_mode,
  output wrf_pkg::stat_t                stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wrf_pkg::PIX_W-1:0]     out_pixel,
  output logic                          out_row_end
);
  import wrf_pkg::*;

  logic [SAMP_W-1:0]        win_r [N_ROWS];
  logic [SAMP_W-1:0]        samp_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [HV_W-1:0]   hv_r;
  logic signed [HV_W-1:0]   rd_data_r;
  logic [PIX_W-1:0]         pix_r;
  logic                     out_valid_r;
  logic [PIX_W-1:0]         out_pixel_r;
  logic                     out_row_end_r;
  logic [HV_W-1:0]          line_mem [N_ROWS][MAX_LINE];

  logic signed [COEF_W-1:0] coef;
  logic signed [OPND_W-1:0] opnd;
  logic signed [PROD_W-1:0] prod;
  logic [SAMP_W-1:0]        h_samp;
  logic signed [ACC_W-1:0]  h_rnd;
  logic signed [ACC_W-1:0]  v_rnd;
  logic signed [ACC_W-1:0]  h_lo;
  logic signed [ACC_W-1:0]  h_hi;
  logic signed [ACC_W-1:0]  pix_max;
  logic                     is12;
  logic                     is8;

  assign is12 = depth_mode[1];
  assign is8  = (depth_mode == DEPTH_8);

  always_comb begin
    h_samp = (cmd.tap == 3'd6) ? samp_r : win_r[cmd.tap];
    if (cmd.h_acc) begin
      coef = tap_coef(h_taps, cmd.tap);
      opnd = $signed({5'd0, h_samp});
    end else begin
      coef = tap_coef(v_taps, cmd.tap);
      opnd = (cmd.tap == 3'd6) ? OPND_W'(hv_r) : OPND_W'(rd_data_r);
    end
    prod = PROD_W'(coef) * PROD_W'(opnd);
  end

  always_comb begin
    h_rnd   = is12 ? ((acc_r + 32'sd16) >>> 5) : ((acc_r + 32'sd4) >>> 3);
    v_rnd   = is12 ? ((acc_r + 32'sd256) >>> 9) : ((acc_r + 32'sd1024) >>> 11);
    h_lo    = is8 ? -32'sd2048 : -32'sd8192;
    h_hi    = is8 ? 32'sd6143 : 32'sd24575;
    pix_max = is8 ? 32'sd255 : (depth_mode == DEPTH_10 ? 32'sd1023 : 32'sd4095);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      samp_r <= sample_in;
    end
    if (!rst_n) begin
      for (int i = 0; i < N_ROWS; i++) begin
        win_r[i] <= '0;
      end
    end else if (cmd.shift) begin
      for (int i = 0; i < N_ROWS - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[N_ROWS-1] <= samp_r;
    end
    if (cmd.load || cmd.h_fin) begin
      acc_r <= '0;
    end else if (cmd.h_acc || cmd.v_acc) begin
      acc_r <= acc_r + ACC_W'(prod);
    end
    if (cmd.h_fin) begin
      if (h_rnd < h_lo) begin
        hv_r <= HV_W'(h_lo);
      end else if (h_rnd > h_hi) begin
        hv_r <= HV_W'(h_hi);
      end else begin
        hv_r <= HV_W'(h_rnd);
      end
    end
    if (cmd.v_fin) begin
      if (v_rnd < 0) begin
        pix_r <= '0;
      end else if (v_rnd > pix_max) begin
        pix_r <= PIX_W'(pix_max);
      end else begin
        pix_r <= PIX_W'(v_rnd);
      end
    end
    if (cmd.out_load) begin
      out_pixel_r   <= pix_r;
      out_row_end_r <= cmd.row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      line_mem[cmd.wr_slot][x] <= hv_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= line_mem[cmd.rd_slot][x];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.out_busy = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_pixel     = out_pixel_r;
  assign out_row_end   = out_row_end_r;

endmodule

FILE: sv/wrf_ctrl.sv
// Controller: counters, row bookkeeping and the state machine that sequences the datapath.
`timescale 1ns / 1ps
module wrf_ctrl #(
  parameter int MAX_LINE = 256,
  parameter int AW       = 8,
  parameter int CW       = 9
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       region_start,
  input  logic [wrf_pkg::CFG_W-1:0]  line_width,
  input  wrf_pkg::stat_t             stat,
  output wrf_pkg::cmd_t              cmd,
  output logic [AW-1:0]              x
);
  import wrf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HMAC,
    S_HRND,
    S_VMAC,
    S_VRND,
    S_WR,
    S_OUT
  } state_t;

  state_t        state_r;
  logic [2:0]    k_r;
  logic [CW-1:0] col_r;
  logic [2:0]    rows_r;
  logic [2:0]    head_r;
  logic [AW-1:0] x_r;
  logic          xval_r;
  logic          full_r;
  logic          last_r;
  logic [2:0]    slot_r;

  logic             accept;
  logic [CMP_W-1:0] c13;
  logic [CMP_W-1:0] lw13;
  logic [CMP_W-1:0] w_eff;
  logic [CMP_W-1:0] x13;
  logic [2:0]       rows_c;
  logic [2:0]       head_c;
  logic             last_c;
  logic             xval_c;
  logic [3:0]       slot_sum;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    c13    = region_start ? '0 : CMP_W'(col_r);
    rows_c = region_start ? '0 : rows_r;
    head_c = region_start ? '0 : head_r;
    lw13   = CMP_W'(line_width);
    if (lw13 == '0) begin
      w_eff = CMP_W'(1);
    end else if (lw13 > CMP_W'(MAX_LINE)) begin
      w_eff = CMP_W'(MAX_LINE);
    end else begin
      w_eff = lw13;
    end
    last_c   = c13 >= w_eff + CMP_W'(5);
    x13      = c13 - CMP_W'(6);
    xval_c   = (c13 >= CMP_W'(6)) && (x13 < CMP_W'(MAX_LINE));
    slot_sum = 4'(slot_r) + 4'(k_r);
    if (slot_sum >= 4'd6) begin
      slot_sum = slot_sum - 4'd6;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = accept;
    cmd.row_end  = last_r;
    cmd.wr_slot  = slot_r;
    cmd.rd_slot  = slot_sum[2:0];
    cmd.tap      = k_r;
    unique case (state_r)
      S_IDLE: begin
      end
      S_HMAC: begin
        cmd.h_acc = 1'b1;
      end
      S_HRND: begin
        cmd.h_fin = 1'b1;
      end
      S_VMAC: begin
        cmd.rd_en = (k_r < 3'd6);
        cmd.v_acc = (k_r != 3'd0);
        cmd.tap   = k_r - 3'd1;
      end
      S_VRND: begin
        cmd.v_fin = 1'b1;
      end
      S_WR: begin
        cmd.wr_en = xval_r;
        cmd.shift = 1'b1;
      end
      S_OUT: begin
        cmd.out_load = !stat.out_busy;
      end
    endcase
  end

  assign x = x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      col_r   <= '0;
      rows_r  <= '0;
      head_r  <= '0;
      xval_r  <= 1'b0;
      full_r  <= 1'b0;
      last_r  <= 1'b0;
      slot_r  <= '0;
      x_r     <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            x_r    <= x13[AW-1:0];
            xval_r <= xval_c;
            full_r <= (rows_c == 3'd6);
            last_r <= last_c;
            slot_r <= head_c;
            k_r    <= '0;
            state_r <= xval_c ? S_HMAC : S_WR;
            if (last_c) begin
              col_r  <= '0;
              rows_r <= (rows_c < 3'd6) ? rows_c + 3'd1 : rows_c;
              head_r <= (head_c == 3'd5) ? 3'd0 : head_c + 3'd1;
            end else begin
              col_r  <= region_start ? CW'(1) : col_r + CW'(1);
              rows_r <= rows_c;
              head_r <= head_c;
            end
          end
        end
        S_HMAC: begin
          k_r <= k_r + 3'd1;
          if (k_r == 3'd6) begin
            state_r <= S_HRND;
          end
        end
        S_HRND: begin
          k_r     <= '0;
          state_r <= full_r ? S_VMAC : S_WR;
        end
        S_VMAC: begin
          k_r <= k_r + 3'd1;
          if (k_r == 3'd7) begin
            state_r <= S_VRND;
          end
        end
        S_VRND: begin
          state_r <= S_WR;
        end
        S_WR: begin
          state_r <= (xval_r && full_r) ? S_OUT : S_IDLE;
        end
        S_OUT: begin
          if (!stat.out_busy) begin
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

FILE: sv/wiener_restoration_filter_core.sv
// Top level of the 7-tap separable Wiener restoration filter: config registers and assertions.
`timescale 1ns / 1ps
`include "wiener_restoration_filter_core_defines.svh"
// Takes padded samples in raster order, one word at a time, and returns one restored pixel
// per output column once six intermediate rows are stored. A single shared multiply-accumulate
// unit does all fourteen products of an item one after another, so an item that yields a
// pixel steps through accept, 7 horizontal taps, rounding, line-store reads with vertical taps,
// rounding, line-store write and output load; an item of a row before the sixth ends after the
// write, and a left-padding item is only accepted and shifted. The next word is accepted while
// the previous pixel still waits in the output register. The line store holds six rows of
// MAX_LINE intermediates, is not cleared after reset, and is only read where it was written.
module wiener_restoration_filter_core #(
  parameter int MAX_LINE = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // [11:0] sample_in
  input  logic                            in_tuser,   // region_start
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // [11:0] pixel_out
  output logic                            out_tlast,  // row_end
  input  logic                            cfg_wr_en,
  input  logic [wrf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wrf_pkg::CFG_W-1:0]       cfg_wdata
);
  import wrf_pkg::*;

  localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int CW = $clog2(MAX_LINE + 6);

  tap_set_t         h_taps_r;
  tap_set_t         v_taps_r;
  logic [1:0]       depth_mode_r;
  logic [CFG_W-1:0] line_width_r;
  cmd_t             cmd;
  stat_t            stat;
  logic [AW-1:0]    x;
  logic [PIX_W-1:0] pixel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_taps_r     <= '0;
      v_taps_r     <= '0;
      depth_mode_r <= '0;
      line_width_r <= CFG_W'(4);
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_H_TAP0:     h_taps_r[0]  <= cfg_wdata[TAP_W-1:0];
        REG_H_TAP1:     h_taps_r[1]  <= cfg_wdata[TAP_W-1:0];
        REG_H_TAP2:     h_taps_r[2]  <= cfg_wdata[TAP_W-1:0];
        REG_V_TAP0:     v_taps_r[0]  <= cfg_wdata[TAP_W-1:0];
        REG_V_TAP1:     v_taps_r[1]  <= cfg_wdata[TAP_W-1:0];
        REG_V_TAP2:     v_taps_r[2]  <= cfg_wdata[TAP_W-1:0];
        REG_DEPTH_MODE: depth_mode_r <= cfg_wdata[1:0];
        REG_LINE_WIDTH: line_width_r <= cfg_wdata;
      endcase
    end
  end

  wrf_ctrl #(
    .MAX_LINE (MAX_LINE),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .region_start (in_tuser),
    .line_width   (line_width_r),
    .stat         (stat),
    .cmd          (cmd),
    .x            (x)
  );

  wrf_dp #(
    .MAX_LINE (MAX_LINE),
    .AW       (AW)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .x           (x),
    .sample_in   (in_tdata[SAMP_W-1:0]),
    .h_taps      (h_taps_r),
    .v_taps      (v_taps_r),
    .depth_mode  (depth_mode_r),
    .stat        (stat),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_pixel   (pixel),
    .out_row_end (out_tlast)
  );

  assign out_tdata = {4'd0, pixel};

  // A word is worked on alone, so the input closes right after it is taken.
  `WRF_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "input open after accept")
  // A new pixel is loaded only as the item ends, which reopens the input.
  `WRF_ASSERT_NOW(a_load_ends_item, $rose(out_tvalid), in_tready, "pixel loaded mid item")

endmodule
